### hdl/pmc_pkg.sv
// Package for the partition map checker: entry, status, state and control types.
// No dependencies; pmc_cell, pmc_conv and the core refer to it by scoped names.
package pmc_pkg;

    localparam int BLK_W = 32;

    typedef logic [BLK_W-1:0] t_blk;

    typedef struct packed {
        t_blk first;
        t_blk last;
    } t_entry;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_INVERTED   = 3'd2,
        ST_OVERLAP    = 3'd3,
        ST_MISALIGNED = 3'd4,
        ST_RANGE      = 3'd5,
        ST_TOO_MANY   = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_EMIT
    } t_state;

    // configuration register indexes
    localparam logic [1:0] CFG_MAP_BLOCK_SIZE = 2'd0;
    localparam logic [1:0] CFG_ERASE_LOG2     = 2'd1;
    localparam logic [1:0] CFG_DEVICE_COUNT   = 2'd2;

    typedef struct packed {
        logic insert;
        logic rotate;
    } t_cell_ctl;

    typedef struct packed {
        logic [31:0] map_block_size;
        logic [4:0]  erase_log2;
    } t_conv_cfg;

    typedef struct packed {
        logic        valid;
        logic        is_last;
        logic        misalign;
        logic [63:0] first;
        logic [63:0] last;
    } t_conv_out;

endpackage

### hdl/pmc_if.sv
// Valid/ready channel interfaces for the partition map checker.
// Depends on nothing; payload widths follow the entry and result fields.
interface pmc_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] start_block;
    logic [31:0] end_block;

    modport source (output valid, output command, output start_block, output end_block,
                    input ready);
    modport sink   (input valid, input command, input start_block, input end_block,
                    output ready);
endinterface

interface pmc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] out_start;
    logic [63:0] out_end;
    logic        final_item;

    modport source (output valid, output status, output out_start, output out_end,
                    output final_item, input ready);
    modport sink   (input valid, input status, input out_start, input out_end,
                    input final_item, output ready);
endinterface

### hdl/pmc_cell.sv
// One cell of the sorted entry chain: holds one entry, shifts up on insert,
// shifts down on rotate. Depends on pmc_pkg.
module pmc_cell (
    input  logic               i_clk,
    input  pmc_pkg::t_cell_ctl i_ctl,
    input  pmc_pkg::t_entry    i_new,
    input  pmc_pkg::t_entry    i_prev,
    input  pmc_pkg::t_entry    i_next,
    input  logic               i_prev_gt,
    input  logic               i_prev_occ,
    input  logic               i_occ,
    output pmc_pkg::t_entry    o_entry,
    output logic               o_gt
);

    pmc_pkg::t_entry r_entry;
    pmc_pkg::t_entry n_entry;

    // occupied and sorting after the new entry
    assign o_gt    = i_occ && (r_entry.first > i_new.first);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.insert) begin
            if (i_prev_gt) begin
                n_entry = i_prev;
            end else if (o_gt || (!i_occ && i_prev_occ)) begin
                n_entry = i_new;
            end
        end else if (i_ctl.rotate) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### hdl/pmc_conv.sv
// Three-stage conversion pipe: map units to erase blocks with alignment flag.
// Depends on pmc_pkg.
module pmc_conv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  logic               i_last,
    input  pmc_pkg::t_entry    i_entry,
    input  pmc_pkg::t_conv_cfg i_cfg,
    output pmc_pkg::t_conv_out o_res,
    output logic               o_busy
);

    logic            r1_valid, r1_last;
    pmc_pkg::t_entry r1_entry;
    logic [63:0]     r1_fo, r1_lp;
    logic            r2_valid, r2_last;
    pmc_pkg::t_entry r2_entry;
    logic [63:0]     r2_fo, r2_lo;
    pmc_pkg::t_conv_out r_res;
    pmc_pkg::t_conv_out n_res;

    logic [63:0] w_bsize;
    logic [63:0] w_erase;
    logic [63:0] w_mask;
    logic        w_convert;

    assign w_bsize   = {32'd0, i_cfg.map_block_size};
    assign w_erase   = 64'd1 << i_cfg.erase_log2;
    assign w_mask    = w_erase - 64'd1;
    assign w_convert = (w_bsize != w_erase);

    always_comb begin
        n_res.valid   = r2_valid;
        n_res.is_last = r2_last;
        if (w_convert) begin
            n_res.misalign = ((r2_fo | r2_lo) & w_mask) != 64'd0;
            n_res.first    = r2_fo >> i_cfg.erase_log2;
            n_res.last     = (r2_lo >> i_cfg.erase_log2) - 64'd1;
        end else begin
            n_res.misalign = 1'b0;
            n_res.first    = {32'd0, r2_entry.first};
            n_res.last     = {32'd0, r2_entry.last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r_res.valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r_res    <= n_res;
        end
        if (i_adv) begin
            r1_last  <= i_last;
            r1_entry <= i_entry;
            r1_fo    <= {32'd0, i_entry.first} * w_bsize;
            r1_lp    <= {32'd0, i_entry.last} * w_bsize;
            r2_last  <= r1_last;
            r2_entry <= r1_entry;
            r2_fo    <= r1_fo;
            r2_lo    <= r1_lp + w_bsize;
        end
    end

    assign o_res  = r_res;
    assign o_busy = r1_valid || r2_valid || r_res.valid;

endmodule

### hdl/partition_map_checker_core.sv
// Top level of the partition map checker: entry chain, conversion pipe,
// sequencer and result register. Depends on pmc_pkg, pmc_if, pmc_cell, pmc_conv.
//
// Usage:
//   i_in  carries load items (command 0, start_block, end_block) and finish
//         items (command 1). A load entry is placed in sorted order in the
//         cell chain at the accepting edge.
//   o_out carries results: one error result, or one result per sorted
//         entry with final_item set on the last one.
//   i_cfg_we/i_cfg_index/i_cfg_data write map_block_size (0),
//   erase_block_log2 (1) and device_block_count (2) while the block is idle.
// Throughput and finish sequence:
//   loads: 1 item per cycle. A finish first scans the whole chain,
//   rotating every cell past the head and draining the pipe, and then
//   decides; an error result appears right after. On success entries
//   are replayed through the pipe and leave at one per cycle while the
//   receiver accepts them. The scan length is set by the rotation of the
//   cell chain through the conversion pipe. No new item is accepted
//   during a finish.
// Reset: map empty, flags clear, registers at 4096 / 17 / 1024.
// Stall: a stalled receiver holds the result register and freezes the
//   chain and the conversion pipe; nothing is lost.
module partition_map_checker_core #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pmc_in_if.sink       i_in,
    pmc_out_if.source    o_out,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    localparam int CW     = $clog2(MAX_ENTRIES + 1);
    localparam int SECOND = (MAX_ENTRIES > 1) ? 1 : 0;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

    // configuration
    logic [31:0] r_map_size;
    logic [4:0]  r_erase_log2;
    logic [31:0] r_dev_count;

    // sequencer
    pmc_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_total, n_total;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_inverted, n_inverted;
    logic            r_overflow, n_overflow;
    logic            r_overlap, n_overlap;
    logic            r_misalign, n_misalign;
    logic            r_range, n_range;

    // result register
    logic             r_out_valid, n_out_valid;
    pmc_pkg::t_status r_out_status, n_out_status;
    logic [63:0]      r_out_start, n_out_start;
    logic [63:0]      r_out_end, n_out_end;
    logic             r_out_final, n_out_final;

    // datapath
    pmc_pkg::t_entry    w_new;
    pmc_pkg::t_entry    w_entry [MAX_ENTRIES];
    logic               w_gt    [MAX_ENTRIES];
    logic               w_occ   [MAX_ENTRIES];
    pmc_pkg::t_cell_ctl w_ctl;
    pmc_pkg::t_conv_cfg w_cfg;
    pmc_pkg::t_conv_out w_conv;
    logic               w_busy;
    logic               w_pipe_adv;
    logic               w_pipe_valid;
    logic               w_in_xfer;
    logic               w_out_free;
    logic               w_feed_last;

    assign w_in_xfer   = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_new.first = i_in.start_block;
    assign w_new.last  = i_in.end_block;
    assign w_feed_last = (r_idx == (r_total - CW'(1)));

    assign w_cfg.map_block_size = r_map_size;
    assign w_cfg.erase_log2     = r_erase_log2;

    // ---------------------------------------------------------------
    // sorted entry chain; cell 0 is the head seen by the pipe
    // ---------------------------------------------------------------
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == MAX_ENTRIES - 1) ? 0 : g + 1;

        assign w_occ[g] = (CW'(g) < r_total);

        pmc_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_new      (w_new),
            .i_prev     (w_entry[PREV]),
            .i_next     (w_entry[NEXT]),
            .i_prev_gt  ((g == 0) ? 1'b0 : w_gt[PREV]),
            .i_prev_occ ((g == 0) ? 1'b1 : w_occ[PREV]),
            .i_occ      (w_occ[g]),
            .o_entry    (w_entry[g]),
            .o_gt       (w_gt[g])
        );
    end

    pmc_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_pipe_adv),
        .i_valid (w_pipe_valid),
        .i_last  (w_feed_last),
        .i_entry (w_entry[0]),
        .i_cfg   (w_cfg),
        .o_res   (w_conv),
        .o_busy  (w_busy)
    );

    // ---------------------------------------------------------------
    // configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_size   <= 32'd4096;
            r_erase_log2 <= 5'd17;
            r_dev_count  <= 32'd1024;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pmc_pkg::CFG_MAP_BLOCK_SIZE: r_map_size   <= i_cfg_data;
                pmc_pkg::CFG_ERASE_LOG2:     r_erase_log2 <= i_cfg_data[4:0];
                pmc_pkg::CFG_DEVICE_COUNT:   r_dev_count  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // sequencer: load / scan / decide / emit
    // ---------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_total      = r_total;
        n_idx        = r_idx;
        n_inverted   = r_inverted;
        n_overflow   = r_overflow;
        n_overlap    = r_overlap;
        n_misalign   = r_misalign;
        n_range      = r_range;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_start  = r_out_start;
        n_out_end    = r_out_end;
        n_out_final  = r_out_final;
        w_ctl.insert = 1'b0;
        w_ctl.rotate = 1'b0;
        w_pipe_adv   = 1'b0;
        w_pipe_valid = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            pmc_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    if (i_in.command) begin
                        n_state    = pmc_pkg::S_SCAN;
                        n_idx      = '0;
                        n_overlap  = 1'b0;
                        n_misalign = 1'b0;
                        n_range    = 1'b0;
                    end else if (r_total == MAX_C) begin
                        n_overflow = 1'b1;       // full store drops the entry
                    end else begin
                        w_ctl.insert = 1'b1;
                        n_total      = r_total + CW'(1);
                        if (i_in.start_block > i_in.end_block) begin
                            n_inverted = 1'b1;
                        end
                    end
                end
            end

            pmc_pkg::S_SCAN: begin
                // full rotation of the chain; head and its neighbor give overlap
                w_pipe_adv = 1'b1;
                if (r_idx != MAX_C) begin
                    w_ctl.rotate = 1'b1;
                    w_pipe_valid = (r_idx < r_total);
                    n_idx        = r_idx + CW'(1);
                    if ((r_total != '0) && (r_idx < (r_total - CW'(1))) &&
                        (w_entry[0].last >= w_entry[SECOND].first)) begin
                        n_overlap = 1'b1;
                    end
                end else if (!w_busy) begin
                    n_state = pmc_pkg::S_DECIDE;
                end
                if (w_conv.valid && w_conv.misalign) begin
                    n_misalign = 1'b1;
                end
                if (w_conv.valid && w_conv.is_last &&
                    (w_conv.last >= {32'd0, r_dev_count})) begin
                    n_range = 1'b1;
                end
            end

            pmc_pkg::S_DECIDE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_start = '0;
                    n_out_end   = '0;
                    n_out_final = 1'b1;
                    n_state     = pmc_pkg::S_IDLE;
                    n_total     = '0;
                    n_inverted  = 1'b0;
                    n_overflow  = 1'b0;
                    priority if (r_overflow) begin
                        n_out_status = pmc_pkg::ST_TOO_MANY;
                    end else if (r_total == '0) begin
                        n_out_status = pmc_pkg::ST_EMPTY;
                    end else if (r_inverted) begin
                        n_out_status = pmc_pkg::ST_INVERTED;
                    end else if (r_overlap) begin
                        n_out_status = pmc_pkg::ST_OVERLAP;
                    end else if (r_misalign) begin
                        n_out_status = pmc_pkg::ST_MISALIGNED;
                    end else if (r_range) begin
                        n_out_status = pmc_pkg::ST_RANGE;
                    end else begin
                        // map is good: replay it through the pipe
                        n_out_valid = r_out_valid && !o_out.ready;
                        n_out_final = r_out_final;
                        n_out_start = r_out_start;
                        n_out_end   = r_out_end;
                        n_state     = pmc_pkg::S_EMIT;
                        n_idx       = '0;
                        n_total     = r_total;
                        n_inverted  = r_inverted;
                        n_overflow  = r_overflow;
                    end
                end
            end

            pmc_pkg::S_EMIT: begin
                if (w_out_free) begin
                    w_pipe_adv   = 1'b1;
                    n_out_valid  = w_conv.valid;
                    n_out_status = pmc_pkg::ST_OK;
                    n_out_start  = w_conv.first;
                    n_out_end    = w_conv.last;
                    n_out_final  = w_conv.is_last;
                    if (r_idx != r_total) begin
                        w_ctl.rotate = 1'b1;
                        w_pipe_valid = 1'b1;
                        n_idx        = r_idx + CW'(1);
                    end
                end
                if ((r_idx == r_total) && !w_busy) begin
                    n_state    = pmc_pkg::S_IDLE;
                    n_total    = '0;
                    n_inverted = 1'b0;
                    n_overflow = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pmc_pkg::S_IDLE;
            r_total     <= '0;
            r_idx       <= '0;
            r_inverted  <= 1'b0;
            r_overflow  <= 1'b0;
            r_overlap   <= 1'b0;
            r_misalign  <= 1'b0;
            r_range     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_idx       <= n_idx;
            r_inverted  <= n_inverted;
            r_overflow  <= n_overflow;
            r_overlap   <= n_overlap;
            r_misalign  <= n_misalign;
            r_range     <= n_range;
            r_out_valid <= n_out_valid;
        end
        r_out_status <= n_out_status;
        r_out_start  <= n_out_start;
        r_out_end    <= n_out_end;
        r_out_final  <= n_out_final;
    end

    // ports
    assign i_in.ready       = (r_state == pmc_pkg::S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.out_start  = r_out_start;
    assign o_out.out_end    = r_out_end;
    assign o_out.final_item = r_out_final;

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= MAX_C)
        else $error("entry count past chain length");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status != pmc_pkg::ST_OK)) |->
        (o_out.final_item && (o_out.out_start == 64'd0) && (o_out.out_end == 64'd0)))
        else $error("error result not a zeroed final transfer");

    a_finish_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_in.command) |=> ((r_state == pmc_pkg::S_SCAN) && (r_idx == '0)))
        else $error("finish did not start a scan");
`endif

endmodule
